### src/stereo_note_tone_synth_unit_defines.svh
// ----------------------------------------------------------------------------
// stereo_note_tone_synth_unit_defines.svh
// Assertion macros shared by the tone synthesizer RTL.
// ----------------------------------------------------------------------------
`ifndef STEREO_NOTE_TONE_SYNTH_UNIT_DEFINES_SVH
`define STEREO_NOTE_TONE_SYNTH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Constants, register map and helper functions of the stereo tone synthesizer.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Default build parameters
  localparam int unsigned DEF_SINE_ENTRIES = 1024;
  localparam int unsigned DEF_PHASE_BITS   = 32;

  // Field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned SCALE_W    = 36;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned AMP_W      = 18;
  localparam int unsigned HZ_W       = 10;
  localparam int unsigned PROD_W     = 34;  // amplitude times sine magnitude
  localparam int unsigned MAG_W      = 19;  // product divided by full scale
  localparam int unsigned STEP_PROD_W = 48; // hertz times phase scale, Q48

  // Configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic        REG_SAMPLE_RATE = 1'b0;  // byte address 0
  localparam logic        REG_PHASE_SCALE = 1'b1;  // byte address 8

  localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd44100;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd6382652533;

  // Item kinds
  localparam logic KIND_NOTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Duration codes
  localparam logic [7:0] DUR_HALF    = 8'd4;
  localparam logic [7:0] DUR_QUARTER = 8'd8;
  localparam logic [7:0] DUR_EIGHTH  = 8'd16;

  localparam logic [AMP_W-1:0] AMP_PER_LEVEL = 18'd1000;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] FULL_SCALE  = 64'd32767;

  // Note letter to frequency in hertz
  function automatic logic [HZ_W-1:0] pitch_hz(input logic [7:0] c);
    case (c)
      "C":     return 10'd261;
      "D":     return 10'd294;
      "E":     return 10'd330;
      "F":     return 10'd349;
      "G":     return 10'd392;
      "A":     return 10'd440;
      "B":     return 10'd494;
      default: return 10'd523;
    endcase
  endfunction

  // Sine series in Q30 for x in [0, pi/2]
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    term = ((term * x2) >> 30) / 6;   neg = neg + term;
    term = ((term * x2) >> 30) / 20;  pos = pos + term;
    term = ((term * x2) >> 30) / 42;  neg = neg + term;
    term = ((term * x2) >> 30) / 72;  pos = pos + term;
    term = ((term * x2) >> 30) / 110; neg = neg + term;
    term = ((term * x2) >> 30) / 156; pos = pos + term;
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // Cosine series in Q30 for x in [0, pi/2]
  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = '0;
    term = ((term * x2) >> 30) / 2;   neg = neg + term;
    term = ((term * x2) >> 30) / 12;  pos = pos + term;
    term = ((term * x2) >> 30) / 30;  neg = neg + term;
    term = ((term * x2) >> 30) / 56;  pos = pos + term;
    term = ((term * x2) >> 30) / 90;  neg = neg + term;
    term = ((term * x2) >> 30) / 132; pos = pos + term;
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // One sine table entry; table depth is 2**log2n (elaboration only)
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned idx,
                                                            input int unsigned log2n);
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] th;
    logic [63:0] v;
    logic [63:0] m;
    a  = 64'(idx) << 2;
    q  = a >> log2n;
    r  = a & ((64'd1 << log2n) - 64'd1);
    th = (HALF_PI_Q30 * r) >> log2n;
    v  = q[0] ? cos_q30(th) : sin_q30(th);
    if (v > Q30_ONE) begin
      v = Q30_ONE;
    end
    m = (v * FULL_SCALE + (Q30_ONE >> 1)) >> 30;
    return (q >= 64'd2) ? SAMPLE_W'(64'd0 - m) : SAMPLE_W'(m);
  endfunction

  // Floor of p / 32767 by folding the top bits back in
  function automatic logic [MAG_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
    logic [MAG_W-1:0] q0;
    logic [MAG_W:0]   t;
    logic [4:0]       q1;
    logic [15:0]      r2;
    q0 = p[PROD_W-1:15];
    t  = {1'b0, q0} + (MAG_W+1)'(p[14:0]);
    q1 = t[19:15];
    r2 = 16'(q1) + 16'(t[14:0]);
    return q0 + MAG_W'(q1) + MAG_W'(r2 >= 16'd32767);
  endfunction

endpackage

### src/sts_in_if.sv
// ----------------------------------------------------------------------------
// sts_in_if
// Note and tick word channel into the tone synthesizer.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       channel;
  logic [7:0] duration_code;
  logic [7:0] pitch_char;
  logic [7:0] amplitude_level;

  modport source (
    output valid, kind, channel, duration_code, pitch_char, amplitude_level,
    input  ready
  );

  modport sink (
    input  valid, kind, channel, duration_code, pitch_char, amplitude_level,
    output ready
  );
endinterface

### src/sts_out_if.sv
// ----------------------------------------------------------------------------
// sts_out_if
// Stereo frame word channel out of the tone synthesizer.
// ----------------------------------------------------------------------------
interface sts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               left_active;
  logic               right_active;
  logic               clipped;

  modport source (
    output valid, left_sample, right_sample, left_active, right_active, clipped,
    input  ready
  );

  modport sink (
    input  valid, left_sample, right_sample, left_active, right_active, clipped,
    output ready
  );
endinterface

### src/stereo_note_tone_synth_unit.sv
// ----------------------------------------------------------------------------
// stereo_note_tone_synth_unit
// Throughput: one word per cycle while out_chan is ready; a tick word's frame
//   leaves the last of four register stages (input, sine read, multiply,
//   scale/saturate), each of which moves whenever the stage after it frees.
// Reset (rst_n low, synchronous): channels silent, phases zero, registers at
//   44100 Hz and its phase scale; the sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
`include "stereo_note_tone_synth_unit_defines.svh"

module stereo_note_tone_synth_unit #(
  parameter int unsigned SINE_ENTRIES = sts_pkg::DEF_SINE_ENTRIES,
  parameter int unsigned PHASE_BITS   = sts_pkg::DEF_PHASE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sts_in_if.sink                            in_chan,
  sts_out_if.source                         out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sts_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sts_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sts_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned LOG2N  = $clog2(SINE_ENTRIES);
  localparam int unsigned SW     = sts_pkg::SAMPLE_W;
  localparam int unsigned CW     = sts_pkg::COUNT_W;
  localparam int unsigned AW     = sts_pkg::AMP_W;
  localparam int unsigned PW     = sts_pkg::PROD_W;
  localparam int unsigned MW     = sts_pkg::MAG_W;
  localparam int unsigned SPW    = sts_pkg::STEP_PROD_W;

  // --------------------------------------------------------------------------
  // Sine table: full cycle, built at elaboration from the integer series.
  // --------------------------------------------------------------------------
  typedef logic signed [SW-1:0] rom_t [SINE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      rom[i] = sts_pkg::sine_entry(i, LOG2N);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // --------------------------------------------------------------------------
  // Configuration registers. A word at byte address 0 is the sample rate, at
  // 8 the phase scale; address bit 3 picks the register.
  // --------------------------------------------------------------------------
  logic [sts_pkg::RATE_W-1:0]  cfg_sample_rate_r;
  logic [sts_pkg::SCALE_W-1:0] cfg_phase_scale_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sample_rate_r <= sts_pkg::RATE_RESET;
      cfg_phase_scale_r <= sts_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3])
        sts_pkg::REG_SAMPLE_RATE: cfg_sample_rate_r <= pwdata[sts_pkg::RATE_W-1:0];
        sts_pkg::REG_PHASE_SCALE: cfg_phase_scale_r <= pwdata[sts_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      sts_pkg::REG_SAMPLE_RATE: prdata = sts_pkg::CFG_DATA_W'(cfg_sample_rate_r);
      sts_pkg::REG_PHASE_SCALE: prdata = sts_pkg::CFG_DATA_W'(cfg_phase_scale_r);
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage ready chain. Each stage loads when it is empty or its word moves on,
  // so bubbles left by note words collapse and the output register alone
  // holds a frame that the sink has not taken.
  // --------------------------------------------------------------------------
  logic in_v_r, s1_v_r, s2_v_r, out_v_r;
  logic rdy0, rdy1, rdy2, rdy_out;
  logic adv0;

  assign rdy_out = !out_v_r || out_chan.ready;
  assign rdy2    = !s2_v_r || rdy_out;
  assign rdy1    = !s1_v_r || rdy2;
  assign rdy0    = !in_v_r || rdy1;
  assign adv0    = in_v_r && rdy1;

  assign in_chan.ready = rdy0;

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  logic       in_kind_r;
  logic       in_channel_r;
  logic [7:0] in_duration_code_r;
  logic [7:0] in_pitch_char_r;
  logic [7:0] in_amplitude_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (rdy0) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      in_kind_r            <= in_chan.kind;
      in_channel_r         <= in_chan.channel;
      in_duration_code_r   <= in_chan.duration_code;
      in_pitch_char_r      <= in_chan.pitch_char;
      in_amplitude_level_r <= in_chan.amplitude_level;
    end
  end

  // --------------------------------------------------------------------------
  // Channel state. A note word rewrites its channel; a tick word advances
  // every channel that still has samples left. Both happen as the word
  // leaves stage 0, so later words always see the updated state.
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_acc_r    [2];
  logic [PHASE_BITS-1:0] phase_step_r   [2];
  logic [CW-1:0]         samples_left_r [2];
  logic [AW-1:0]         note_amp_r     [2];

  logic [CW-1:0]  note_len;
  logic [AW-1:0]  note_amp;
  logic [SPW-1:0] step_prod;
  logic [1:0]     ch_active;

  // Duration in samples: a shift of the sample rate, zero for unknown codes
  always_comb begin
    case (in_duration_code_r)
      sts_pkg::DUR_HALF:    note_len = CW'(cfg_sample_rate_r >> 1);
      sts_pkg::DUR_QUARTER: note_len = CW'(cfg_sample_rate_r >> 2);
      sts_pkg::DUR_EIGHTH:  note_len = CW'(cfg_sample_rate_r >> 3);
      default:              note_len = '0;
    endcase
  end

  assign note_amp = AW'(in_amplitude_level_r) * sts_pkg::AMP_PER_LEVEL;

  // Phase step = (hertz * phase scale) >> (48 - PHASE_BITS), top bits of Q48
  assign step_prod = SPW'(sts_pkg::pitch_hz(in_pitch_char_r)) * SPW'(cfg_phase_scale_r);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      ch_active[c] = (samples_left_r[c] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        phase_acc_r[c]    <= '0;
        phase_step_r[c]   <= '0;
        samples_left_r[c] <= '0;
        note_amp_r[c]     <= '0;
      end
    end else if (adv0) begin
      if (in_kind_r == sts_pkg::KIND_NOTE) begin
        samples_left_r[in_channel_r] <= note_len;
        note_amp_r[in_channel_r]     <= note_amp;
        phase_step_r[in_channel_r]   <= step_prod[SPW-1 -: PHASE_BITS];
        phase_acc_r[in_channel_r]    <= '0;   // first sample at phase zero
      end else begin
        for (int c = 0; c < 2; c++) begin
          if (ch_active[c]) begin
            phase_acc_r[c]    <= phase_acc_r[c] + phase_step_r[c];
            samples_left_r[c] <= samples_left_r[c] - CW'(1);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sine read. The table index is the top LOG2N bits of the phase.
  // An idle channel carries amplitude zero, which yields a zero sample.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] s1_sine_r [2];
  logic [AW-1:0]        s1_amp_r  [2];
  logic [1:0]           s1_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_v_r && (in_kind_r == sts_pkg::KIND_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      for (int c = 0; c < 2; c++) begin
        s1_sine_r[c] <= SINE_ROM[phase_acc_r[c][PHASE_BITS-1 -: LOG2N]];
        s1_amp_r[c]  <= ch_active[c] ? note_amp_r[c] : '0;
      end
      s1_act_r <= ch_active;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: amplitude times sine magnitude; keep the sign aside.
  // --------------------------------------------------------------------------
  logic [PW-1:0] s2_prod_r [2];
  logic [1:0]    s2_neg_r;
  logic [1:0]    s2_act_r;
  logic [SW-1:0] sine_mag  [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sine_mag[c] = s1_sine_r[c][SW-1] ? SW'(-s1_sine_r[c]) : SW'(s1_sine_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      for (int c = 0; c < 2; c++) begin
        s2_prod_r[c] <= PW'(s1_amp_r[c]) * PW'(sine_mag[c]);
        s2_neg_r[c]  <= s1_sine_r[c][SW-1];
      end
      s2_act_r <= s1_act_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide by full scale (truncating), saturate to 16 bits, flag
  // any clip. Negative side allows a magnitude of 32768.
  // --------------------------------------------------------------------------
  logic [MW-1:0]        mag      [2];
  logic signed [SW-1:0] samp_nxt [2];
  logic [1:0]           clip_nxt;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      mag[c] = sts_pkg::div_full_scale(s2_prod_r[c]);
      if (s2_neg_r[c]) begin
        clip_nxt[c] = (mag[c] > MW'(32768));
        samp_nxt[c] = clip_nxt[c] ? SW'(17'h08000) : SW'(17'h10000 - 17'(mag[c]));
      end else begin
        clip_nxt[c] = (mag[c] > MW'(32767));
        samp_nxt[c] = clip_nxt[c] ? SW'(32767) : SW'(mag[c]);
      end
    end
  end

  logic signed [SW-1:0] out_left_sample_r;
  logic signed [SW-1:0] out_right_sample_r;
  logic                 out_left_active_r;
  logic                 out_right_active_r;
  logic                 out_clipped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_out) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && s2_v_r) begin
      out_left_sample_r  <= samp_nxt[0];
      out_right_sample_r <= samp_nxt[1];
      out_left_active_r  <= s2_act_r[0];
      out_right_active_r <= s2_act_r[1];
      out_clipped_r      <= |clip_nxt;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.left_sample  = out_left_sample_r;
  assign out_chan.right_sample = out_right_sample_r;
  assign out_chan.left_active  = out_left_active_r;
  assign out_chan.right_active = out_right_active_r;
  assign out_chan.clipped      = out_clipped_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `STS_ASSERT_NEXT(a_note_no_frame, clk, rst_n,
                   adv0 && (in_kind_r == sts_pkg::KIND_NOTE), !s1_v_r,
                   "note word produced a frame")
  `STS_ASSERT_NEXT(a_count_down, clk, rst_n,
                   adv0 && (in_kind_r == sts_pkg::KIND_TICK) && ch_active[0],
                   samples_left_r[0] == $past(samples_left_r[0]) - CW'(1),
                   "left sample count did not step down on tick")
  `STS_ASSERT_NOW(a_idle_silent, clk, rst_n,
                  out_v_r && !out_left_active_r && !out_right_active_r,
                  (out_left_sample_r == '0) && (out_right_sample_r == '0) && !out_clipped_r,
                  "idle channels gave a nonzero frame")
  `STS_ASSERT_NOW(a_clip_needs_note, clk, rst_n,
                  out_v_r && out_clipped_r,
                  out_left_active_r || out_right_active_r,
                  "clip flagged with no sounding channel")

endmodule
